// ===== sv/cordic_tangent_unit_macros.svh =====
`ifndef CORDIC_TANGENT_UNIT_MACROS_SVH
`define CORDIC_TANGENT_UNIT_MACROS_SVH
// assertion helpers
`define CTU_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CTU_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== sv/ctu_pkg.sv =====
package ctu_pkg;
    localparam int ITERATIONS = 10;
    localparam int ANGLE_WIDTH = 16;
    localparam int RESULT_WIDTH = 32;
    localparam int FRAC = RESULT_WIDTH / 2;
    localparam int XW = 36;
    localparam int QW = XW + FRAC;
    localparam logic signed [XW-1:0] HALF_PI_Q30 = XW'(64'sd1686629713);
    localparam logic signed [XW-1:0] ONE_Q30 = XW'(64'sd1073741824);

    typedef logic signed [XW-1:0] t_word;

    typedef struct packed {
        logic  vld;
        logic  zero;
        t_word x;
        t_word y;
        t_word z;
    } t_rot;

    function automatic t_word atan_q30(input int i);
        t_word r;
        case (i)
            0: r = XW'(64'sd843314857);
            1: r = XW'(64'sd497837829);
            2: r = XW'(64'sd263043837);
            3: r = XW'(64'sd133525159);
            4: r = XW'(64'sd67021687);
            5: r = XW'(64'sd33543516);
            6: r = XW'(64'sd16775851);
            7: r = XW'(64'sd8388437);
            8: r = XW'(64'sd4194283);
            9: r = XW'(64'sd2097149);
            10: r = XW'(64'sd1048575);
            default: r = XW'(64'sd1) <<< (30 - i);
        endcase
        return r;
    endfunction
endpackage

// ===== sv/ctu_stage.sv =====
module ctu_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  int            i_idx,
    input  ctu_pkg::t_rot i_d,
    output ctu_pkg::t_rot o_d
);
    ctu_pkg::t_rot r_d, n_d;
    ctu_pkg::t_word xs, ys;

    always_comb begin
        xs = i_d.x >>> i_idx;
        ys = i_d.y >>> i_idx;
        n_d = i_d;
        if (i_d.z < 0) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + ctu_pkg::atan_q30(i_idx);
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - ctu_pkg::atan_q30(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d <= '0;
        else r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

// ===== sv/ctu_divider.sv =====
`include "cordic_tangent_unit_macros.svh"
module ctu_divider (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ctu_pkg::t_rot i_d,
    output logic          o_vld,
    output logic [ctu_pkg::RESULT_WIDTH-1:0] o_tangent,
    output logic          o_overflow
);
    localparam int QW = ctu_pkg::QW;
    localparam int XW = ctu_pkg::XW;
    localparam int N = QW;
    localparam int RW = ctu_pkg::RESULT_WIDTH;

    typedef struct packed {
        logic          vld;
        logic          special;
        logic          neg;
        logic          ypos;
        logic [XW-1:0] d;
        logic [QW-1:0] num;
        logic [XW:0]   rem;
        logic [QW-1:0] q;
    } t_div;

    t_div r_p [0:N];
    t_div n_0;
    t_div n_p [1:N];

    always_comb begin
        logic [XW-1:0] my, mx;
        my = i_d.y[XW-1] ? XW'(-i_d.y) : XW'(i_d.y);
        mx = i_d.x[XW-1] ? XW'(-i_d.x) : XW'(i_d.x);
        n_0.vld = i_d.vld;
        n_0.special = i_d.zero || (i_d.x == '0);
        n_0.neg = i_d.zero ? 1'b0 : (i_d.y[XW-1] != i_d.x[XW-1]);
        n_0.ypos = !i_d.y[XW-1] && (i_d.y != '0);
        n_0.d = mx;
        n_0.num = i_d.zero ? '0 : {my, {ctu_pkg::FRAC{1'b0}}};
        n_0.rem = '0;
        n_0.q = '0;
    end

    always_comb begin
        for (int k = 1; k <= N; k++) begin
            logic [XW+1:0] t;
            n_p[k] = r_p[k-1];
            t = {r_p[k-1].rem, r_p[k-1].num[QW-1]};
            n_p[k].num = r_p[k-1].num << 1;
            if (t >= {2'b0, r_p[k-1].d}) begin
                t = t - {2'b0, r_p[k-1].d};
                n_p[k].q = {r_p[k-1].q[QW-2:0], 1'b1};
            end else begin
                n_p[k].q = {r_p[k-1].q[QW-2:0], 1'b0};
            end
            n_p[k].rem = t[XW:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) r_p[k] <= '0;
        end else begin
            r_p[0] <= n_0;
            for (int k = 1; k <= N; k++) r_p[k] <= n_p[k];
        end
    end

    logic [QW-1:0] lim_pos, lim_neg;
    logic [RW-1:0] r_tan, n_tan;
    logic r_ovf, n_ovf, r_vld;
    t_div f;

    always_comb begin
        f = r_p[N];
        lim_pos = QW'({1'b0, {(RW-1){1'b1}}});
        lim_neg = QW'({1'b1, {(RW-1){1'b0}}});
        n_ovf = 1'b0;
        if (f.special && f.d == '0 && f.num != '0) begin
            n_tan = f.ypos ? lim_pos[RW-1:0] : lim_neg[RW-1:0];
            n_ovf = 1'b1;
        end else if (f.special && f.num == '0 && f.d == '0) begin
            n_tan = lim_neg[RW-1:0];
            n_ovf = 1'b1;
        end else if (f.neg) begin
            if (f.q > lim_neg) begin
                n_tan = lim_neg[RW-1:0];
                n_ovf = 1'b1;
            end else begin
                n_tan = RW'(-f.q);
            end
        end else begin
            if (f.q > lim_pos) begin
                n_tan = lim_pos[RW-1:0];
                n_ovf = 1'b1;
            end else begin
                n_tan = f.q[RW-1:0];
            end
        end
        if (f.special && f.d != '0) begin
            n_tan = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tan <= n_tan;
        r_ovf <= n_ovf;
        if (!i_rst_n) r_vld <= 1'b0;
        else r_vld <= f.vld;
    end

    assign o_vld = r_vld;
    assign o_tangent = r_tan;
    assign o_overflow = r_ovf;

    `CTU_ASSERT_NEXT(a_vld_flow, i_clk, i_rst_n, r_p[N].vld, r_vld)
    `CTU_ASSERT_IMPL(a_rem_lt_d, i_clk, i_rst_n, r_p[N].vld && r_p[N].d != '0,
        r_p[N].rem < {1'b0, r_p[N].d})
    `CTU_ASSERT_IMPL(a_ovf_sat, i_clk, i_rst_n, r_vld && r_ovf,
        r_tan == lim_pos[RW-1:0] || r_tan == lim_neg[RW-1:0])
endmodule

// ===== sv/cordic_tangent_unit.sv =====
// Pipeline: ITERATIONS + 1 CORDIC stages, then RESULT_WIDTH/2 + 36 + 2 divider
// stages of the bit-per-stage restoring divider.
// Throughput: one word per cycle; busy is always low.
// Reset: synchronous active low; clears all pipeline registers except r_tan/r_ovf.
// Results appear for one cycle on o_valid; the receiver cannot stall.
`include "cordic_tangent_unit_macros.svh"
module cordic_tangent_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [ctu_pkg::ANGLE_WIDTH-1:0] i_angle,
    output logic        o_valid,
    output logic signed [ctu_pkg::RESULT_WIDTH-1:0] o_tangent,
    output logic        o_overflow
);
    localparam int XW = ctu_pkg::XW;
    localparam int IT = ctu_pkg::ITERATIONS;

    ctu_pkg::t_rot r_in, n_in;
    ctu_pkg::t_rot st [0:IT];
    logic [ctu_pkg::RESULT_WIDTH-1:0] tan_u;

    assign busy = 1'b0;

    always_comb begin
        ctu_pkg::t_word a;
        a = ctu_pkg::t_word'(i_angle) <<< (32 - ctu_pkg::ANGLE_WIDTH);
        if (a > ctu_pkg::HALF_PI_Q30) a = ctu_pkg::HALF_PI_Q30;
        if (a < -ctu_pkg::HALF_PI_Q30) a = -ctu_pkg::HALF_PI_Q30;
        n_in.vld = start && !busy;
        n_in.zero = (i_angle == '0);
        n_in.x = ctu_pkg::ONE_Q30;
        n_in.y = '0;
        n_in.z = a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in <= '0;
        else r_in <= n_in;
    end

    assign st[0] = r_in;

    for (genvar g = 0; g < IT; g++) begin : g_rot
        ctu_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_idx  (g),
            .i_d    (st[g]),
            .o_d    (st[g+1])
        );
    end

    ctu_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_d       (st[IT]),
        .o_vld     (o_valid),
        .o_tangent (tan_u),
        .o_overflow(o_overflow)
    );

    assign o_tangent = $signed(tan_u);

    `CTU_ASSERT_NEXT(a_in_vld, i_clk, i_rst_n, start && !busy, r_in.vld)
    `CTU_ASSERT_IMPL(a_zero_res, i_clk, i_rst_n, st[IT].vld && st[IT].zero,
        st[IT].x[XW-1] == 1'b0)
endmodule
